/* rtl/core/decimal_integer_formatter_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the decimal integer formatter
// Same-cycle-implication and next-cycle-implication checks, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_INTEGER_FORMATTER_TOP_ASSERT_SVH
`define DECIMAL_INTEGER_FORMATTER_TOP_ASSERT_SVH

// same-cycle implication
`define DIF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DIF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/dif_pkg.sv */
// ----------------------------------------------------------------------------
// dif_pkg
// Shared types and constants of the decimal integer formatter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dif_pkg;

    localparam int VALUE_W     = 64;   // width of the input field
    localparam int DIGIT_DEPTH = 20;   // decimal digits of a 64-bit magnitude
    localparam int DIGIT_W     = 5;    // holds 0..DIGIT_DEPTH
    localparam int BCD_W       = DIGIT_DEPTH * 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIGNED_MODE  = 3'd0,
        CFG_SIGN_STYLE   = 3'd1,
        CFG_LEFT_JUSTIFY = 3'd2,
        CFG_MIN_WIDTH    = 3'd3,
        CFG_MIN_DIGITS   = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        STYLE_NONE  = 2'd0,
        STYLE_SPACE = 2'd1,
        STYLE_PLUS  = 2'd2
    } t_sign_style;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    // commands to the BCD unit, at most one per cycle
    typedef struct packed {
        logic load;
        logic dabble;
        logic norm;
        logic pop;
    } t_bcd_ctl;

    typedef struct packed {
        logic [3:0]         top_digit;
        logic [DIGIT_W-1:0] ndig;
    } t_bcd_sts;

endpackage

/* rtl/core/dif_in_if.sv */
// ----------------------------------------------------------------------------
// dif_in_if
// Input channel: one integer per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dif_in_if;
    logic                       valid;
    logic                       ready;
    logic [dif_pkg::VALUE_W-1:0] value_bits;

    modport source (output valid, output value_bits, input ready);
    modport sink   (input valid, input value_bits, output ready);
endinterface

/* rtl/core/dif_out_if.sv */
// ----------------------------------------------------------------------------
// dif_out_if
// Output channel: one ASCII character per transfer, with end-of-text flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dif_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last_char;

    modport source (output valid, output character, output last_char, input ready);
    modport sink   (input valid, input character, input last_char, output ready);
endinterface

/* rtl/core/dif_bcd_unit.sv */
// ----------------------------------------------------------------------------
// dif_bcd_unit
// Shift-add-3 binary to BCD converter, one bit per dabble step, plus
// leading-zero strip and digit pop by nibble shifts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dif_bcd_unit #(
    parameter int VALUE_BITS = 64
) (
    input  logic                     i_clk,
    input  dif_pkg::t_bcd_ctl        i_ctl,
    input  logic [VALUE_BITS-1:0]    i_bin,
    output dif_pkg::t_bcd_sts        o_sts
);

    logic [dif_pkg::BCD_W-1:0]   r_bcd,  n_bcd;
    logic [VALUE_BITS-1:0]       r_bin,  n_bin;
    logic [dif_pkg::DIGIT_W-1:0] r_ndig, n_ndig;
    logic [dif_pkg::BCD_W-1:0]   w_corr;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < dif_pkg::DIGIT_DEPTH; i++) begin
            if (r_bcd[i*4 +: 4] >= 4'd5) begin
                w_corr[i*4 +: 4] = r_bcd[i*4 +: 4] + 4'd3;
            end else begin
                w_corr[i*4 +: 4] = r_bcd[i*4 +: 4];
            end
        end
    end

    always_comb begin
        n_bcd  = r_bcd;
        n_bin  = r_bin;
        n_ndig = r_ndig;
        if (i_ctl.load) begin
            n_bcd  = '0;
            n_bin  = i_bin;
            n_ndig = dif_pkg::DIGIT_W'(dif_pkg::DIGIT_DEPTH);
        end else if (i_ctl.dabble) begin
            n_bcd = {w_corr[dif_pkg::BCD_W-2:0], r_bin[VALUE_BITS-1]};
            n_bin = {r_bin[VALUE_BITS-2:0], 1'b0};
        end else if (i_ctl.norm) begin
            n_bcd  = {r_bcd[dif_pkg::BCD_W-5:0], 4'd0};
            n_ndig = r_ndig - 1'b1;
        end else if (i_ctl.pop) begin
            n_bcd = {r_bcd[dif_pkg::BCD_W-5:0], 4'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd  <= n_bcd;
        r_bin  <= n_bin;
        r_ndig <= n_ndig;
    end

    assign o_sts.top_digit = r_bcd[dif_pkg::BCD_W-1 -: 4];
    assign o_sts.ndig      = r_ndig;

endmodule

/* rtl/core/decimal_integer_formatter_top.sv */
// An accepted integer is converted by the shift-add-3 BCD unit, one
// input bit per cycle. Leading zero digits are then stripped one per
// cycle (up to 19 digits) until the leading digit is found. S_CALC then
// sizes the field, and then one character leaves per cycle while the
// output side is ready. The next integer is taken in S_IDLE; a new integer
// is taken only once the last character of the previous one sits in the
// output register.
// ----------------------------------------------------------------------------
// decimal_integer_formatter_top
// printf-style %d / %u decimal text, one ASCII character per output transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module decimal_integer_formatter_top #(
    parameter int MAX_FIELD  = 40,
    parameter int VALUE_BITS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dif_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dif_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    dif_in_if.sink                            i_in,
    dif_out_if.source                         o_out
);

`include "decimal_integer_formatter_top_assert.svh"

    localparam int CW_RAW = $clog2(MAX_FIELD + 2);
    localparam int CW     = (CW_RAW > dif_pkg::CFG_DATA_W) ? CW_RAW : dif_pkg::CFG_DATA_W;
    localparam int IW     = $clog2(VALUE_BITS);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CONV = 5'b00010,
        S_NORM = 5'b00100,
        S_CALC = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    // configuration
    logic                             r_signed_mode;
    logic [1:0]                       r_sign_style;
    logic                             r_left_justify;
    logic [dif_pkg::CFG_DATA_W-1:0]   r_min_width;
    logic [dif_pkg::CFG_DATA_W-1:0]   r_min_digits;

    t_state                     r_state, n_state;
    logic [IW-1:0]              r_iter, n_iter;
    logic                       r_has_sign, n_has_sign;
    logic [7:0]                 r_sign_ch, n_sign_ch;
    logic [CW-1:0]              r_pad, n_pad;
    logic [CW-1:0]              r_zeros, n_zeros;
    logic [dif_pkg::DIGIT_W-1:0] r_digs, n_digs;
    logic [CW-1:0]              r_remain, n_remain;
    logic                       r_out_valid, n_out_valid;
    logic [7:0]                 r_char, n_char;
    logic                       r_last, n_last;

    dif_pkg::t_bcd_ctl          w_ctl;
    dif_pkg::t_bcd_sts          w_sts;
    logic [VALUE_BITS-1:0]      w_val;
    logic                       w_neg;
    logic [VALUE_BITS-1:0]      w_mag;
    logic                       w_in_xfer;
    logic                       w_emit;
    logic [CW-1:0]              w_prec, w_width, w_ndig, w_digmax, w_body, w_total;

    dif_bcd_unit #(
        .VALUE_BITS (VALUE_BITS)
    ) u_bcd (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .i_bin (w_mag),
        .o_sts (w_sts)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_xfer  = i_in.valid && i_in.ready;

    assign w_val = i_in.value_bits[VALUE_BITS-1:0];
    assign w_neg = r_signed_mode && w_val[VALUE_BITS-1];
    assign w_mag = w_neg ? (~w_val + 1'b1) : w_val;

    // field sizing, used in S_CALC
    assign w_prec   = (CW'(r_min_digits) > CW'(MAX_FIELD)) ? CW'(MAX_FIELD)
                                                           : CW'(r_min_digits);
    assign w_width  = (CW'(r_min_width) > CW'(MAX_FIELD)) ? CW'(MAX_FIELD)
                                                          : CW'(r_min_width);
    assign w_ndig   = CW'(w_sts.ndig);
    assign w_digmax = (w_prec > w_ndig) ? w_prec : w_ndig;
    assign w_body   = w_digmax + CW'(r_has_sign);
    assign w_total  = (w_body > w_width) ? w_body : w_width;

    assign w_emit = (r_state == S_EMIT) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state     = r_state;
        n_iter      = r_iter;
        n_has_sign  = r_has_sign;
        n_sign_ch   = r_sign_ch;
        n_pad       = r_pad;
        n_zeros     = r_zeros;
        n_digs      = r_digs;
        n_remain    = r_remain;
        n_char      = r_char;
        n_last      = r_last;
        n_out_valid = r_out_valid && !o_out.ready;
        w_ctl       = '0;

        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    w_ctl.load = 1'b1;
                    n_iter     = '0;
                    n_has_sign = 1'b0;
                    n_sign_ch  = dif_pkg::CH_MINUS;
                    if (w_neg) begin
                        n_has_sign = 1'b1;
                    end else if (r_signed_mode
                                 && r_sign_style == dif_pkg::STYLE_SPACE) begin
                        n_has_sign = 1'b1;
                        n_sign_ch  = dif_pkg::CH_SPACE;
                    end else if (r_signed_mode
                                 && r_sign_style == dif_pkg::STYLE_PLUS) begin
                        n_has_sign = 1'b1;
                        n_sign_ch  = dif_pkg::CH_PLUS;
                    end
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                w_ctl.dabble = 1'b1;
                n_iter       = r_iter + 1'b1;
                if (r_iter == IW'(VALUE_BITS - 1)) begin
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                // strip leading zero digits, keep at least one
                if (w_sts.ndig > dif_pkg::DIGIT_W'(1) && w_sts.top_digit == 4'd0) begin
                    w_ctl.norm = 1'b1;
                end else begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_pad    = w_total - w_body;
                n_zeros  = w_digmax - w_ndig;
                n_digs   = w_sts.ndig;
                n_remain = w_total;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (w_emit) begin
                    n_out_valid = 1'b1;
                    n_last      = (r_remain == CW'(1));
                    n_remain    = r_remain - 1'b1;
                    if (!r_left_justify && r_pad != '0) begin
                        n_char = dif_pkg::CH_SPACE;
                        n_pad  = r_pad - 1'b1;
                    end else if (r_has_sign) begin
                        n_char     = r_sign_ch;
                        n_has_sign = 1'b0;
                    end else if (r_zeros != '0) begin
                        n_char  = dif_pkg::CH_ZERO;
                        n_zeros = r_zeros - 1'b1;
                    end else if (r_digs != '0) begin
                        n_char    = dif_pkg::CH_ZERO + {4'd0, w_sts.top_digit};
                        w_ctl.pop = 1'b1;
                        n_digs    = r_digs - 1'b1;
                    end else begin
                        n_char = dif_pkg::CH_SPACE;
                        n_pad  = r_pad - 1'b1;
                    end
                    if (r_remain == CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode  <= 1'b1;
            r_sign_style   <= 2'd0;
            r_left_justify <= 1'b0;
            r_min_width    <= '0;
            r_min_digits   <= '0;
        end else if (i_cfg_we) begin
            case (dif_pkg::t_cfg_idx'(i_cfg_idx))
                dif_pkg::CFG_SIGNED_MODE:  r_signed_mode  <= i_cfg_data[0];
                dif_pkg::CFG_SIGN_STYLE:   r_sign_style   <= i_cfg_data[1:0];
                dif_pkg::CFG_LEFT_JUSTIFY: r_left_justify <= i_cfg_data[0];
                dif_pkg::CFG_MIN_WIDTH:    r_min_width    <= i_cfg_data;
                dif_pkg::CFG_MIN_DIGITS:   r_min_digits   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_has_sign  <= 1'b0;
            r_pad       <= '0;
            r_zeros     <= '0;
            r_digs      <= '0;
            r_remain    <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_has_sign  <= n_has_sign;
            r_pad       <= n_pad;
            r_zeros     <= n_zeros;
            r_digs      <= n_digs;
            r_remain    <= n_remain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_iter    <= n_iter;
        r_sign_ch <= n_sign_ch;
        r_char    <= n_char;
        r_last    <= n_last;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.character = r_char;
    assign o_out.last_char = r_last;

    // remaining count matches the characters still owed from each section
    `DIF_ASSERT_NOW(a_remain_sum, i_clk, i_rst_n, r_state == S_EMIT, r_remain == CW'(r_pad + r_zeros + CW'(r_digs) + CW'(r_has_sign)), "remaining count out of step with field sections")
    // stripping leaves a leading nonzero digit unless the value is zero
    `DIF_ASSERT_NOW(a_norm_done, i_clk, i_rst_n, r_state == S_CALC, w_sts.ndig != '0 && (w_sts.ndig == dif_pkg::DIGIT_W'(1) || w_sts.top_digit != 4'd0), "digit strip ended on a leading zero")
    // never sit in emit with nothing left to send
    `DIF_ASSERT_NOW(a_emit_nonempty, i_clk, i_rst_n, r_state == S_EMIT, r_remain != '0, "emit phase with empty field")
    // the final character ends the item and frees the input
    `DIF_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, w_emit && r_remain == CW'(1), r_state == S_IDLE && r_last, "last character did not close the item")

endmodule
